/* design/tcgp_pkg.sv */
// Shared types and constants for the text cursor glyph placer.
// No dependencies; compile first.
`default_nettype none

package tcgp_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HEIGHT = 1'b1;

  localparam logic [8:0] WIDTH_RESET  = 9'd320;
  localparam logic [7:0] HEIGHT_RESET = 8'd200;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] CODE_LIMIT   = 8'd128;
  localparam int         GLYPH_WIDTH  = 8;
  localparam int         LEFT_MARGIN  = 4;
  localparam int         TOP_EXTRA    = 8;

  typedef enum logic {
    OP_PLACE = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] char_code;
    logic [3:0] font_row_index;
    logic [7:0] font_row_bits;
    logic [7:0] ink_color;
  } in_item_t;

  typedef struct packed {
    logic [8:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] row_mask;
    logic [7:0] pixel_color;
    logic       last_row;
  } out_item_t;

endpackage

`default_nettype wire

/* design/tcgp_stream_if.sv */
// Valid/ready stream channel carrying one payload per request.
// Payload type is supplied by the instantiating level.
`default_nettype none

interface tcgp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/text_cursor_glyph_placer.sv */
// Text window character placer with a loadable glyph memory.
// Depends on tcgp_pkg and tcgp_stream_if.
//
//   channel   dir  contents
//   request   in   operation, char_code, font_row_index, font_row_bits, ink_color
//   result    out  pixel_x, pixel_y, row_mask, pixel_color, last_row
//   cfg       in   cfg_we, cfg_index, cfg_data (window_width, window_height)
//
// A drawn character is walked row by row: one glyph memory read per result row.
// The next request is taken in the cycle the last row of the previous character
// is read, so characters stream back to back. Result stalls hold the row walker.
// Reset clears the cursor and restores the window size; the glyph memory holds
// garbage until loaded.
`default_nettype none

module text_cursor_glyph_placer #(
  parameter int GLYPH_ROWS  = 16,
  parameter int GLYPH_COUNT = 128,
  parameter int MAX_WIDTH   = 320,
  parameter int MAX_HEIGHT  = 200
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  tcgp_stream_if.sink                          request,
  tcgp_stream_if.source                        result,
  input  wire logic                            cfg_we,
  input  wire logic [tcgp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tcgp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcgp_pkg::*;

  localparam int DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(GLYPH_ROWS);
  localparam int LW    = $clog2(17 * GLYPH_ROWS + MAX_WIDTH + MAX_HEIGHT + 600);

  logic [7:0] glyph_mem [DEPTH];

  logic [8:0] window_width;
  logic [7:0] window_height;
  logic [5:0] cursor_column, cursor_column_next;
  logic [3:0] cursor_row, cursor_row_next;

  logic          busy;
  logic [RW-1:0] row_cnt;
  logic [AW-1:0] base_addr;
  logic [8:0]    cur_x;
  logic [7:0]    cur_y0;
  logic [7:0]    cur_color;

  logic       out_valid;
  logic [8:0] out_x;
  logic [7:0] out_y;
  logic [7:0] out_mask;
  logic [7:0] out_color;
  logic       out_last;

  logic [LW-1:0] wc, hc;
  logic          advance, row_done, accept, draw;
  logic [5:0]    draw_col;
  logic [3:0]    draw_row;
  logic [3:0]    row_inc;
  in_item_t      req;

  function automatic logic row_fits(input logic [3:0] r_in, input logic [LW-1:0] h_in);
    row_fits = ((LW'(r_in) + LW'(2)) * LW'(GLYPH_ROWS) + LW'(TOP_EXTRA)) <= h_in;
  endfunction

  function automatic logic col_fits(input logic [5:0] c_in, input logic [LW-1:0] w_in);
    col_fits = (LW'(c_in) + LW'(2)) * LW'(GLYPH_WIDTH) <= w_in;
  endfunction

  assign req = request.payload;

  assign wc = (LW'(window_width) > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : LW'(window_width);
  assign hc = (LW'(window_height) > LW'(MAX_HEIGHT)) ? LW'(MAX_HEIGHT) : LW'(window_height);

  assign advance  = busy && (!out_valid || result.ready);
  assign row_done = advance && (row_cnt == RW'(GLYPH_ROWS - 1));
  assign request.ready = !busy || row_done;
  assign accept   = request.valid && request.ready;
  assign row_inc  = cursor_row + 4'd1;

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    draw               = 1'b0;
    draw_col           = cursor_column;
    draw_row           = cursor_row;
    if (accept && req.operation == OP_PLACE) begin
      if (req.char_code == NEWLINE_CODE) begin
        cursor_column_next = '0;
        if (row_fits(cursor_row, hc)) begin
          cursor_row_next = row_inc;
        end
      end else if (req.char_code < CODE_LIMIT && row_fits(cursor_row, hc)) begin
        if (!col_fits(cursor_column, wc)) begin
          cursor_row_next    = row_inc;
          cursor_column_next = '0;
          if (row_fits(row_inc, hc)) begin
            draw               = 1'b1;
            draw_col           = '0;
            draw_row           = row_inc;
            cursor_column_next = 6'd1;
          end
        end else begin
          draw               = 1'b1;
          cursor_column_next = cursor_column + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_width  <= WIDTH_RESET;
      window_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_WIDTH:  window_width  <= cfg_data[8:0];
        REG_WINDOW_HEIGHT: window_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
    end else begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
    end
  end

  // glyph memory: one write port for loads, one registered read for the row walker
  always_ff @(posedge clk) begin
    if (accept && req.operation == OP_LOAD &&
        {1'b0, req.char_code} < 9'(GLYPH_COUNT) &&
        {1'b0, req.font_row_index} < 5'(GLYPH_ROWS)) begin
      glyph_mem[AW'(req.char_code) * AW'(GLYPH_ROWS) + AW'(req.font_row_index)]
        <= req.font_row_bits;
    end
    if (advance) begin
      out_mask <= glyph_mem[base_addr + AW'(row_cnt)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      row_cnt <= '0;
    end else if (draw) begin
      busy    <= 1'b1;
      row_cnt <= '0;
    end else if (row_done) begin
      busy    <= 1'b0;
      row_cnt <= '0;
    end else if (advance) begin
      row_cnt <= row_cnt + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (draw) begin
      base_addr <= AW'(req.char_code) * AW'(GLYPH_ROWS);
      cur_x     <= 9'(LEFT_MARGIN) + {draw_col, 3'b000};
      cur_y0    <= 8'(GLYPH_ROWS + 4) + 8'(LW'(draw_row) * LW'(GLYPH_ROWS));
      cur_color <= req.ink_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x     <= cur_x;
      out_y     <= cur_y0 + 8'(row_cnt);
      out_color <= cur_color;
      out_last  <= (row_cnt == RW'(GLYPH_ROWS - 1));
    end
  end

  assign result.valid               = out_valid;
  assign result.payload.pixel_x     = out_x;
  assign result.payload.pixel_y     = out_y;
  assign result.payload.row_mask    = out_mask;
  assign result.payload.pixel_color = out_color;
  assign result.payload.last_row    = out_last;

endmodule

`default_nettype wire
